FILE: rtl/dtsl_pkg.sv
// ----------------------------------------------------------------------------
// dtsl_pkg
// shared constants, entry layout and codes of the disc track sector locator
// ----------------------------------------------------------------------------
package dtsl_pkg;

    localparam int MAX_TRACKS      = 128;
    localparam int SECTOR_BYTES    = 2352;
    localparam int LEAD_IN_SECTORS = 150;   // 75 frames a second, two seconds

    localparam int TRK_AW   = $clog2(MAX_TRACKS);
    localparam int LBA_W    = 19;
    localparam int LEN_W    = LBA_W + 1;                // pregap plus frames
    // lead-in plus MAX_TRACKS full spans, exact, never wraps
    localparam int BEGIN_W  = $clog2(LEAD_IN_SECTORS + MAX_TRACKS * (2 ** LEN_W)) + 1;
    localparam int END_W    = 20;
    localparam int SEEK_W   = LBA_W + 1;                // signed sector distance
    localparam int SB_W     = $clog2(SECTOR_BYTES + 1) + 1;
    localparam int PROD_W   = 32;                       // signed seek times sector size
    localparam int OFS_W    = 32;

    localparam logic [BEGIN_W-1:0] END_MAX = BEGIN_W'(20'hFFFFF);

    typedef struct packed {
        logic [LBA_W-1:0] pregap;
        logic [LBA_W-1:0] frames;
        logic [OFS_W-1:0] offset;
        logic [1:0]       kind;
    } entry_t;

    typedef enum logic {
        MODE_WRITE  = 1'b0,
        MODE_LOOKUP = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_PREGAP   = 2'd1,
        ST_NO_TRACK = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_MUL,
        S_ADD
    } state_t;

endpackage

FILE: rtl/disc_track_sector_locator.sv
// ----------------------------------------------------------------------------
// disc_track_sector_locator
// timing: a track write reaches the memory in the cycle after its transfer; a lookup
//   walks n entries (n the track count, capped at the table depth) one entry a cycle
//   through the single read port, then passes the multiply and add states, where it
//   waits for a free result slot; requests, writes one a cycle, are taken only when idle
// reset: clears the control state, the track count and the result valid; the
//   track memory is not cleared and reads undefined until written
// ----------------------------------------------------------------------------
module disc_track_sector_locator
(
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration: number of valid track entries
    input  logic                         cfg_wr_en,
    input  logic [7:0]                   cfg_wr_data,

    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic [6:0]                   track_index,
    input  logic [dtsl_pkg::LBA_W-1:0]   pregap_frames,
    input  logic [dtsl_pkg::LBA_W-1:0]   track_frames,
    input  logic [dtsl_pkg::OFS_W-1:0]   file_offset,
    input  logic [1:0]                   track_kind,
    input  logic [dtsl_pkg::LBA_W-1:0]   position_lba,

    // result channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [6:0]                   track_number,
    output logic [1:0]                   kind_out,
    output logic [dtsl_pkg::OFS_W-1:0]   byte_offset,
    output logic [dtsl_pkg::END_W-1:0]   disc_end_lba
);

    import dtsl_pkg::*;

    localparam logic signed [SB_W-1:0] SECTOR_BYTES_S = SB_W'(SECTOR_BYTES);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t                     state_reg, state_next;
    logic [7:0]                 count_reg;              // configured track count
    logic [7:0]                 n_reg, n_next;          // tracks to walk for this lookup
    logic [7:0]                 chk_reg, chk_next;      // entry whose data is on the read port
    logic [LBA_W-1:0]           pos_reg, pos_next;
    logic [BEGIN_W-1:0]         begin_reg, begin_next;  // running track begin address
    logic                       found_reg, found_next;
    logic [6:0]                 hit_idx_reg, hit_idx_next;
    logic [LBA_W-1:0]           hit_begin_reg, hit_begin_next;
    logic [LBA_W-1:0]           hit_pregap_reg, hit_pregap_next;
    logic [OFS_W-1:0]           hit_offset_reg, hit_offset_next;
    logic [1:0]                 hit_kind_reg, hit_kind_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;

    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 status_reg, status_next;
    logic [6:0]                 track_number_reg, track_number_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [OFS_W-1:0]           byte_offset_reg, byte_offset_next;
    logic [END_W-1:0]           end_reg, end_next;

    // ------------------------------------------------------------------
    // track memory, one entry per track, registered read
    // ------------------------------------------------------------------
    entry_t                     mem [MAX_TRACKS];
    entry_t                     rd_data;
    entry_t                     wr_data;
    logic [TRK_AW-1:0]          rd_addr;
    logic                       wr_en;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[track_index[TRK_AW-1:0]] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign wr_data = '{pregap: pregap_frames, frames: track_frames,
                       offset: file_offset, kind: track_kind};

    // ------------------------------------------------------------------
    // handshake and control outputs
    // ------------------------------------------------------------------
    logic in_xfer;
    logic out_free;     // result slot empty or being taken this cycle
    logic last_entry;
    logic [7:0] chk_inc;

    assign in_xfer    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign chk_inc    = chk_reg + 8'd1;
    assign last_entry = (chk_inc == n_reg);

    always_comb
    begin
        in_ready = 1'b0;
        wr_en    = 1'b0;
        rd_addr  = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                // writes land straight away; an index beyond the table is dropped
                wr_en    = in_valid && (mode == MODE_WRITE)
                           && ({1'b0, track_index} < 8'(MAX_TRACKS));
                rd_addr  = '0;  // first entry, ready for the walk
            end
            S_WALK:
            begin
                rd_addr = chk_inc[TRK_AW-1:0];  // prefetch the following entry
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (mode == MODE_LOOKUP))
                begin
                    // with no valid tracks there is nothing to walk
                    if (count_reg == 8'd0)
                        state_next = S_MUL;
                    else
                        state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (last_entry)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]           span_len;
    logic [BEGIN_W-1:0]         span_end;
    logic                       in_span;
    logic [LBA_W-1:0]           sect_dist;  // sectors from track begin, never negative
    logic signed [SEEK_W-1:0]   seek;
    logic signed [OFS_W+1:0]    ofs_sum;

    assign span_len = {1'b0, rd_data.pregap} + {1'b0, rd_data.frames};
    assign span_end = begin_reg + BEGIN_W'(span_len);
    assign in_span  = (BEGIN_W'(pos_reg) >= begin_reg) && (BEGIN_W'(pos_reg) < span_end);

    assign sect_dist = pos_reg - hit_begin_reg;
    assign seek      = $signed({1'b0, sect_dist}) - $signed({1'b0, hit_pregap_reg});

    assign ofs_sum  = $signed({2'b00, hit_offset_reg})
                      + $signed({{(OFS_W+2-PROD_W){prod_reg[PROD_W-1]}}, prod_reg});

    always_comb
    begin
        n_next            = n_reg;
        chk_next          = chk_reg;
        pos_next          = pos_reg;
        begin_next        = begin_reg;
        found_next        = found_reg;
        hit_idx_next      = hit_idx_reg;
        hit_begin_next    = hit_begin_reg;
        hit_pregap_next   = hit_pregap_reg;
        hit_offset_next   = hit_offset_reg;
        hit_kind_next     = hit_kind_reg;
        prod_next         = prod_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        status_next       = status_reg;
        track_number_next = track_number_reg;
        kind_next         = kind_reg;
        byte_offset_next  = byte_offset_reg;
        end_next          = end_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (mode == MODE_LOOKUP))
                begin
                    n_next     = (count_reg > 8'(MAX_TRACKS)) ? 8'(MAX_TRACKS) : count_reg;
                    chk_next   = 8'd0;
                    pos_next   = position_lba;
                    begin_next = BEGIN_W'(LEAD_IN_SECTORS);
                    found_next = 1'b0;
                end
            end
            S_WALK:
            begin
                // first track whose span holds the address wins
                if (!found_reg && in_span)
                begin
                    found_next      = 1'b1;
                    hit_idx_next    = chk_reg[6:0];
                    hit_begin_next  = begin_reg[LBA_W-1:0];
                    hit_pregap_next = rd_data.pregap;
                    hit_offset_next = rd_data.offset;
                    hit_kind_next   = rd_data.kind;
                end
                begin_next = span_end;
                chk_next   = chk_inc;
            end
            S_MUL:
            begin
                prod_next = PROD_W'(seek * SECTOR_BYTES_S);
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    end_next          = (begin_reg > END_MAX) ? END_MAX[END_W-1:0]
                                                              : begin_reg[END_W-1:0];
                    status_next       = ST_NO_TRACK;
                    track_number_next = '0;
                    kind_next         = '0;
                    byte_offset_next  = '0;
                    if (found_reg)
                    begin
                        track_number_next = hit_idx_reg;
                        kind_next         = hit_kind_reg;
                        if (ofs_sum[OFS_W+1])
                        begin
                            // sector sits before the first stored sector
                            status_next = ST_PREGAP;
                        end
                        else
                        begin
                            status_next      = ST_DATA;
                            byte_offset_next = ofs_sum[OFS_W] ? '1 : ofs_sum[OFS_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            n_reg         <= 8'd0;
            chk_reg       <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            n_reg         <= n_next;
            chk_reg       <= chk_next;
            if (cfg_wr_en)
                count_reg <= cfg_wr_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg          <= pos_next;
        begin_reg        <= begin_next;
        hit_idx_reg      <= hit_idx_next;
        hit_begin_reg    <= hit_begin_next;
        hit_pregap_reg   <= hit_pregap_next;
        hit_offset_reg   <= hit_offset_next;
        hit_kind_reg     <= hit_kind_next;
        prod_reg         <= prod_next;
        status_reg       <= status_next;
        track_number_reg <= track_number_next;
        kind_reg         <= kind_next;
        byte_offset_reg  <= byte_offset_next;
        end_reg          <= end_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign track_number = track_number_reg;
    assign kind_out     = kind_reg;
    assign byte_offset  = byte_offset_reg;
    assign disc_end_lba = end_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (chk_reg < n_reg))
        else $error("walk pointer beyond track count");

    a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == MODE_LOOKUP))
        |=> ((state_reg == S_WALK) || (state_reg == S_MUL)))
        else $error("lookup transfer did not start the walk");

    a_hit_before_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_MUL) && found_reg) |-> (hit_begin_reg <= pos_reg))
        else $error("hit track begins after the looked-up sector");

    a_result_from_add: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_ADD))
        else $error("result raised outside the final stage");

    a_no_result_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (mode == MODE_WRITE)) |=> (state_reg == S_IDLE))
        else $error("track write left the idle state");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the disc track sector locator: track writes and
// sector lookups run in phases with different track counts and layouts, and
// every lookup result is checked field by field against a shadow of the table
// ----------------------------------------------------------------------------
module tb_top;

    import dtsl_pkg::*;

    localparam int          RANDOM_ITEMS = 1750;
    localparam int          QUIET_AFTER  = 1450;          // no idling past this point
    localparam int          DRAIN_CYCLES = MAX_TRACKS + 20;
    localparam int          LONG_HOLD    = 400;
    localparam int          STALL_LIMIT  = 5000;
    localparam longint      LBA_TOP      = (longint'(1) << LBA_W) - 1;
    localparam longint      OFS_CLAMP    = 64'h0000_0000_FFFF_FFFF;
    localparam logic [19:0] END_CLAMP    = 20'hFFFFF;

    // one request as offered on the request channel
    typedef struct {
        mode_t            op;
        logic [6:0]       index;
        logic [LBA_W-1:0] pregap;
        logic [LBA_W-1:0] frames;
        logic [OFS_W-1:0] offset;
        logic [1:0]       kind;
        logic [LBA_W-1:0] lba;
    } track_req_t;

    // the lookup result we expect to see
    typedef struct {
        status_t          st;
        logic [6:0]       track;
        logic [1:0]       kind;
        logic [OFS_W-1:0] offset;
        logic [END_W-1:0] end_lba;
    } sector_hit_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             cfg_wr_en     = 1'b0;
    logic [7:0]       cfg_wr_data   = '0;
    logic             in_valid      = 1'b0;
    logic             in_ready;
    logic             mode          = 1'b0;
    logic [6:0]       track_index   = '0;
    logic [LBA_W-1:0] pregap_frames = '0;
    logic [LBA_W-1:0] track_frames  = '0;
    logic [OFS_W-1:0] file_offset   = '0;
    logic [1:0]       track_kind    = '0;
    logic [LBA_W-1:0] position_lba  = '0;
    logic             out_valid;
    logic             out_ready     = 1'b0;
    logic [1:0]       status;
    logic [6:0]       track_number;
    logic [1:0]       kind_out;
    logic [OFS_W-1:0] byte_offset;
    logic [END_W-1:0] disc_end_lba;

    disc_track_sector_locator i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .track_index   (track_index),
        .pregap_frames (pregap_frames),
        .track_frames  (track_frames),
        .file_offset   (file_offset),
        .track_kind    (track_kind),
        .position_lba  (position_lba),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .track_number  (track_number),
        .kind_out      (kind_out),
        .byte_offset   (byte_offset),
        .disc_end_lba  (disc_end_lba)
    );

    // requests waiting for the driver, lookup results waiting for the dut
    track_req_t  pending_reqs[$];
    sector_hit_t expected_hits[$];
    track_req_t  next_req;
    sector_hit_t exp_hit;

    // sent_cnt belongs to the driver, taken_cnt to the monitor
    int unsigned sent_cnt     = 0;
    int unsigned taken_cnt    = 0;
    int unsigned fail_cnt     = 0;
    int unsigned quiet_cycles = 0;

    // idling controls; the on flags and hold_req are set by the stimulus process on a rising edge
    bit          tx_idle_on = 1'b0;
    bit          rx_idle_on = 1'b0;
    int unsigned tx_gap     = 0;
    int unsigned rx_gap     = 0;
    int unsigned hold_req   = 0;
    int unsigned hold_seen  = 0;

    // shadow of the track table and count, updated on accepted transfers and config writes
    logic [LBA_W-1:0] trk_pregap [MAX_TRACKS];
    logic [LBA_W-1:0] trk_frames [MAX_TRACKS];
    logic [OFS_W-1:0] trk_offset [MAX_TRACKS];
    logic [1:0]       trk_kind   [MAX_TRACKS];
    logic [7:0]       trk_count = '0;

    // layout as the stimulus has queued it, used to aim lookups at spans
    int plan_pregap [MAX_TRACKS];
    int plan_frames [MAX_TRACKS];
    int plan_count = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // sector lookup on the shadow table
    // ------------------------------------------------------------------------
    function automatic sector_hit_t locate_sector(input logic [LBA_W-1:0] lba);
        sector_hit_t res;
        longint      pos;
        longint      span_begin;
        longint      span_len;
        longint      hit_begin;
        longint      seek;
        longint      ofs;
        int          n;
        int          hit;
        int          i;
        bit          found;
        pos        = longint'(lba);
        n          = (trk_count > MAX_TRACKS) ? MAX_TRACKS : int'(trk_count);
        span_begin = LEAD_IN_SECTORS;
        hit_begin  = 0;
        hit        = 0;
        found      = 1'b0;
        // first span holding the address wins, zero-length spans never hold one
        for (i = 0; i < n; i++)
        begin
            span_len = longint'(trk_pregap[i]) + longint'(trk_frames[i]);
            if (!found && pos >= span_begin && pos < span_begin + span_len)
            begin
                found     = 1'b1;
                hit       = i;
                hit_begin = span_begin;
            end
            span_begin += span_len;
        end
        res.st      = ST_NO_TRACK;
        res.track   = '0;
        res.kind    = '0;
        res.offset  = '0;
        res.end_lba = (span_begin > longint'(END_CLAMP)) ? END_CLAMP : END_W'(span_begin);
        if (found)
        begin
            // signed sector distance from the first stored sector
            seek      = pos - hit_begin - longint'(trk_pregap[hit]);
            ofs       = longint'(trk_offset[hit]) + seek * SECTOR_BYTES;
            res.track = 7'(hit);
            res.kind  = trk_kind[hit];
            // pregap status only when the image offset goes negative
            if (ofs < 0)
                res.st = ST_PREGAP;
            else
            begin
                res.st     = ST_DATA;
                res.offset = (ofs > OFS_CLAMP) ? '1 : OFS_W'(ofs);
            end
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_cnt++;
        end
    endtask

    // ------------------------------------------------------------------------
    // driver: presents queued requests on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        // the offered request only moves on once its transfer has happened
        if (taken_cnt == sent_cnt)
        begin
            if (tx_gap != 0)
            begin
                tx_gap--;
                in_valid <= 1'b0;
            end
            else if (tx_idle_on && $urandom_range(0, 9) == 0)
            begin
                tx_gap = $urandom_range(0, 18);
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                next_req = pending_reqs.pop_front();
                mode          <= next_req.op;
                track_index   <= next_req.index;
                pregap_frames <= next_req.pregap;
                track_frames  <= next_req.frames;
                file_offset   <= next_req.offset;
                track_kind    <= next_req.kind;
                position_lba  <= next_req.lba;
                in_valid      <= 1'b1;
                sent_cnt++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // result side back-pressure, with the occasional long hold-off
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            rx_gap    = LONG_HOLD;
        end
        if (rx_gap != 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 9) == 0)
        begin
            rx_gap = $urandom_range(0, 18);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // monitor: samples both channels on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // result transfer first, a lookup taken this edge cannot answer yet
            if (out_valid && out_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("result transfer with no lookup outstanding: status %0d, track %0d",
                           status, track_number);
                    fail_cnt++;
                end
                else
                begin
                    exp_hit = expected_hits.pop_front();
                    check_field("status", exp_hit.st, status);
                    check_field("track_number", exp_hit.track, track_number);
                    check_field("kind_out", exp_hit.kind, kind_out);
                    check_field("byte_offset", exp_hit.offset, byte_offset);
                    check_field("disc_end_lba", exp_hit.end_lba, disc_end_lba);
                end
            end
            if (cfg_wr_en)
                trk_count = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                taken_cnt++;
                if (mode == MODE_WRITE)
                begin
                    trk_pregap[track_index] = pregap_frames;
                    trk_frames[track_index] = track_frames;
                    trk_offset[track_index] = file_offset;
                    trk_kind[track_index]   = track_kind;
                end
                else
                    expected_hits.insert(expected_hits.size(), locate_sector(position_lba));
            end
            // watchdog on cycles without any transfer
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_write(input int idx, input logic [LBA_W-1:0] pg, fr,
                               input logic [OFS_W-1:0] ofs, input logic [1:0] kd);
        track_req_t r;
        r.op     = MODE_WRITE;
        r.index  = 7'(idx);
        r.pregap = pg;
        r.frames = fr;
        r.offset = ofs;
        r.kind   = kd;
        r.lba    = LBA_W'($urandom);       // don't care on a write
        pending_reqs.insert(pending_reqs.size(), r);
        plan_pregap[idx] = int'(pg);
        plan_frames[idx] = int'(fr);
    endtask

    task automatic queue_lookup(input logic [LBA_W-1:0] lba);
        track_req_t r;
        r.op     = MODE_LOOKUP;
        r.index  = 7'($urandom);
        r.pregap = LBA_W'($urandom);
        r.frames = LBA_W'($urandom);
        r.offset = $urandom;
        r.kind   = 2'($urandom);
        r.lba    = lba;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // scale 0 packs many short tracks, 2 spans the full field range
    task automatic queue_random_entry(input int idx, input int scale);
        logic [LBA_W-1:0] pg;
        logic [LBA_W-1:0] fr;
        logic [OFS_W-1:0] ofs;
        case (scale)
            0:
            begin
                pg = LBA_W'($urandom_range(0, 8));
                fr = LBA_W'($urandom_range(0, 60));
            end
            1:
            begin
                pg = LBA_W'($urandom_range(0, 3000));
                fr = LBA_W'($urandom_range(0, 30000));
            end
            default:
            begin
                pg = LBA_W'($urandom);
                fr = LBA_W'($urandom);
            end
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            pg = '0;
            fr = '0;
        end
        // small offsets make the pregap go negative, big ones saturate
        case ($urandom_range(0, 2))
            0:       ofs = $urandom_range(0, 20000);
            1:       ofs = $urandom;
            default: ofs = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        endcase
        queue_write(idx, pg, fr, ofs, 2'($urandom));
    endtask

    function automatic longint plan_begin(input int t);
        longint b;
        int     i;
        b = LEAD_IN_SECTORS;
        for (i = 0; i < t; i++)
            b += plan_pregap[i] + plan_frames[i];
        return b;
    endfunction

    // mostly aimed at span and pregap edges of the queued layout
    function automatic logic [LBA_W-1:0] pick_lba();
        longint b;
        longint a;
        int     t;
        int     len;
        if (plan_count == 0 || $urandom_range(0, 9) == 0)
            return LBA_W'($urandom);
        if ($urandom_range(0, 9) == 0)
            return LBA_W'($urandom_range(0, LEAD_IN_SECTORS + 8));
        t   = $urandom_range(0, plan_count - 1);
        b   = plan_begin(t);
        len = plan_pregap[t] + plan_frames[t];
        case ($urandom_range(0, 7))
            0:       a = b - 1;
            1:       a = b;
            2:       a = b + plan_pregap[t] - 1;
            3:       a = b + plan_pregap[t];
            4:       a = b + len - 1;
            5:       a = b + len;
            default: a = b + $urandom_range(0, len);
        endcase
        if (a < 0 || a > LBA_TOP)
            return LBA_W'($urandom);
        return LBA_W'(a);
    endfunction

    // sender pause until every result is back, then let trailing writes settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || sent_cnt != taken_cnt || expected_hits.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_track_count(input int value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 8'(value);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        plan_count = (value > MAX_TRACKS) ? MAX_TRACKS : value;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // stimulus: reset, directed cases, then random phases
    // ------------------------------------------------------------------------
    initial
    begin
        int made;
        int phase;
        int n;
        int scale;
        int burst;
        int i;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // empty table: no track anywhere, end is the lead-in alone
        queue_lookup('0);
        queue_lookup('1);

        set_track_count(5);
        queue_write(0, 19'd0, 19'd100, 32'd0, 2'd0);             // 150..249
        queue_write(1, 19'd20, 19'd50, 32'd0, 2'd1);             // pregap 250..269
        queue_write(2, 19'd10, 19'd30, 32'hFFFF_FF00, 2'd2);     // offset near the top
        queue_write(3, 19'd0, 19'd0, 32'd5, 2'd3);               // zero-length track
        queue_write(4, '1, '1, '1, 2'd3);                        // pushes the end past its clamp
        queue_write(127, '1, '1, '1, 2'd1);                      // last entry, outside the count
        queue_lookup(19'd149);                                   // below the lead-in
        queue_lookup(19'd150);
        queue_lookup(19'd249);
        queue_lookup(19'd250);                                   // pregap, negative offset
        queue_lookup(19'd269);
        queue_lookup(19'd270);
        queue_lookup(19'd320);                                   // pregap, offset still positive
        queue_lookup(19'd340);                                   // byte offset saturates
        queue_lookup(19'd360);                                   // skips the zero-length track
        queue_lookup('1);

        made  = 0;
        phase = 0;
        while (made < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:          n = 0;
                1:          n = MAX_TRACKS;
                2:          n = $urandom_range(MAX_TRACKS + 1, 255);
                3, 4, 5:    n = $urandom_range(17, MAX_TRACKS - 1);
                default:    n = $urandom_range(1, 16);
            endcase
            // make sure the count extremes come early
            if (phase == 0)
                n = 255;
            else if (phase == 1)
                n = 0;
            set_track_count(n);

            if (made >= QUIET_AFTER)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            else
            begin
                i = $urandom_range(0, 5);
                tx_idle_on = (i == 1 || i >= 3);
                rx_idle_on = (i == 2 || i >= 3);
            end
            // long receiver hold-off while the sender keeps offering
            if (phase == 2 || phase == 7)
            begin
                tx_idle_on = 1'b0;
                hold_req++;
            end

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: scale = 0;
                6, 7, 8:          scale = 1;
                default:          scale = 2;
            endcase
            // every entry inside the count is written before any lookup
            for (i = 0; i < plan_count; i++)
                queue_random_entry(i, scale);
            made += plan_count;

            burst = $urandom_range(30, 100);
            for (i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    queue_random_entry($urandom_range(0, MAX_TRACKS - 1), $urandom_range(0, 2));
                else
                    queue_lookup(pick_lba());
            end
            made += burst;
            phase++;
        end

        wait_drained();
        if (fail_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dtsl_pkg.sv
rtl/disc_track_sector_locator.sv
bench/tb_top.sv
